// File: hw/rtl/arlpf_pkg.sv
// Shared types and constants for the adaptive RC low-pass filter.
// No dependencies.
package arlpf_pkg;

   localparam int unsigned SAMPLE_WIDTH = 16;
   localparam int unsigned CFG_WIDTH    = 16;
   localparam int unsigned CSR_IDX_WIDTH = 8;
   localparam int unsigned COUNT_WIDTH  = 17;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_DIFF_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_COUNT_LIMIT    = 8'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_BASE_COEFF     = 8'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_COEFF_STEP     = 8'd3;

   localparam logic [CFG_WIDTH-1:0] RST_DIFF_THRESHOLD = 16'd256;
   localparam logic [CFG_WIDTH-1:0] RST_COUNT_LIMIT    = 16'd8;
   localparam logic [CFG_WIDTH-1:0] RST_BASE_COEFF     = 16'd3277;
   localparam logic [CFG_WIDTH-1:0] RST_COEFF_STEP     = 16'd328;

   // Q1.15 unity
   localparam logic [CFG_WIDTH-1:0] COEFF_ONE = 16'h8000;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] diff_threshold;
      logic [CFG_WIDTH-1:0] count_limit;
      logic [CFG_WIDTH-1:0] base_coeff;
      logic [CFG_WIDTH-1:0] coeff_step;
   } cfg_type;

endpackage

// File: hw/rtl/arlpf_csr.sv
// Configuration register bank of the adaptive RC low-pass filter.
// Depends on arlpf_pkg.
module arlpf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [arlpf_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [arlpf_pkg::CFG_WIDTH-1:0]     csr_data,
   output arlpf_pkg::cfg_type                  cfg
);

   arlpf_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.diff_threshold <= arlpf_pkg::RST_DIFF_THRESHOLD;
         cfg_ff.count_limit    <= arlpf_pkg::RST_COUNT_LIMIT;
         cfg_ff.base_coeff     <= arlpf_pkg::RST_BASE_COEFF;
         cfg_ff.coeff_step     <= arlpf_pkg::RST_COEFF_STEP;
      end else if (csr_valid) begin
         case (csr_index)
            arlpf_pkg::REG_DIFF_THRESHOLD: cfg_ff.diff_threshold <= csr_data;
            arlpf_pkg::REG_COUNT_LIMIT:    cfg_ff.count_limit    <= csr_data;
            arlpf_pkg::REG_BASE_COEFF:     cfg_ff.base_coeff     <= csr_data;
            arlpf_pkg::REG_COEFF_STEP:     cfg_ff.coeff_step     <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

// File: hw/rtl/arlpf_core.sv
// Filter state and per-sample update: direction tracking, run counting,
// coefficient adaptation and the Q1.15 multiply-accumulate. Depends on arlpf_pkg.
module arlpf_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     step,
   input  logic signed [arlpf_pkg::SAMPLE_WIDTH-1:0] sample,
   input  arlpf_pkg::cfg_type                       cfg,
   output logic signed [arlpf_pkg::SAMPLE_WIDTH-1:0] filtered
);

   localparam int unsigned SW = arlpf_pkg::SAMPLE_WIDTH;
   localparam int unsigned CW = arlpf_pkg::CFG_WIDTH;
   localparam int unsigned NW = arlpf_pkg::COUNT_WIDTH;

   logic                 primed_ff, primed_in;
   logic signed [SW-1:0] last_ff, last_in;
   logic                 rising_ff, rising_in;
   logic [NW-1:0]        count_ff, count_in;
   logic [CW-1:0]        coeff_ff, coeff_in;

   logic signed [SW:0]     diff;
   logic [SW:0]            mag;
   logic                   rising;
   logic [NW-1:0]          count_inc;
   logic [CW:0]            coeff_sum;
   logic [CW-1:0]          coeff_incd;
   logic [CW-1:0]          base_sat;
   logic signed [2*SW+1:0] product;
   logic signed [SW+2:0]   y_wide;
   logic signed [SW-1:0]   y_sat;

   always_comb begin
      diff      = $signed({sample[SW-1], sample}) - $signed({last_ff[SW-1], last_ff});
      rising    = !diff[SW] && (diff != '0);
      mag       = diff[SW] ? $unsigned(-diff) : $unsigned(diff);
      count_inc = count_ff + NW'(1) + ((mag > {1'b0, cfg.diff_threshold}) ? NW'(2) : NW'(0));
      coeff_sum = {1'b0, coeff_ff} + {1'b0, cfg.coeff_step};
      coeff_incd = (coeff_sum > {1'b0, arlpf_pkg::COEFF_ONE}) ? arlpf_pkg::COEFF_ONE
                                                              : coeff_sum[CW-1:0];
      base_sat  = (cfg.base_coeff > arlpf_pkg::COEFF_ONE) ? arlpf_pkg::COEFF_ONE
                                                          : cfg.base_coeff;

      primed_in = 1'b1;
      rising_in = rising;
      count_in  = count_ff;
      coeff_in  = coeff_ff;
      if (!primed_ff) begin
         rising_in = 1'b0;
         count_in  = '0;
         coeff_in  = base_sat;
      end else if (rising == rising_ff) begin
         count_in = count_inc;
         if (count_inc > {1'b0, cfg.count_limit}) begin
            count_in = '0;
            coeff_in = coeff_incd;
         end
      end else begin
         count_in = '0;
         coeff_in = base_sat;
      end

      // floor(coeff * diff / 2^15) is an arithmetic shift of the product
      product = $signed({1'b0, coeff_in}) * diff;
      y_wide  = $signed({{3{last_ff[SW-1]}}, last_ff}) + product[2*SW+1:CW-1];
      if (y_wide > $signed((SW+3)'(32767)))
         y_sat = 16'sh7FFF;
      else if (y_wide < -$signed((SW+3)'(32768)))
         y_sat = -16'sh8000;
      else
         y_sat = y_wide[SW-1:0];

      last_in  = primed_ff ? y_sat : sample;
      filtered = last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         last_ff   <= '0;
         rising_ff <= 1'b0;
         count_ff  <= '0;
         coeff_ff  <= '0;
      end else if (step) begin
         primed_ff <= primed_in;
         last_ff   <= last_in;
         rising_ff <= rising_in;
         count_ff  <= count_in;
         coeff_ff  <= coeff_in;
      end
   end

endmodule

// File: hw/rtl/adaptive_rc_lowpass_filter.sv
// Adaptive RC low-pass filter, top level: input register, filter update, result register.
// A req sample is registered in in_sample_ff, filtered, and registered in out_data_ff.
// Throughput: one sample per cycle while rsp_tready is high, set by the combinational
// state update loop in arlpf_core. Reset (synchronous, active high): filter unprimed,
// registers at defaults, both stages empty. Depends on arlpf_pkg, arlpf_csr, arlpf_core.
module adaptive_rc_lowpass_filter (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic signed [arlpf_pkg::SAMPLE_WIDTH-1:0] req_tdata,  // [15:0] sample
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic signed [arlpf_pkg::SAMPLE_WIDTH-1:0] rsp_tdata,  // [15:0] filtered
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [arlpf_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [arlpf_pkg::CFG_WIDTH-1:0]          csr_data
);

   arlpf_pkg::cfg_type cfg;

   logic                                     in_valid_ff;
   logic signed [arlpf_pkg::SAMPLE_WIDTH-1:0] in_sample_ff;
   logic                                     out_valid_ff;
   logic signed [arlpf_pkg::SAMPLE_WIDTH-1:0] out_data_ff;
   logic signed [arlpf_pkg::SAMPLE_WIDTH-1:0] filtered;
   logic                                     advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   arlpf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   arlpf_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .sample   (in_sample_ff),
      .cfg      (cfg),
      .filtered (filtered)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready)
            in_valid_ff <= req_tvalid;
         if (advance)
            out_valid_ff <= 1'b1;
         else if (rsp_tready)
            out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid)
         in_sample_ff <= req_tdata;
      if (advance)
         out_data_ff <= filtered;
   end

endmodule
